### rtl/mfa_pkg.sv
// ----------------------------------------------------------------------------
// Metaball field accumulate package
// Shared widths, controller state type and the per-axis distance function.
// ----------------------------------------------------------------------------
package mfa_pkg;

	localparam int VOX_W     = 5;   // voxel grid index
	localparam int CEN_W     = 16;  // signed Q8.8 ball center
	localparam int RAD_W     = 20;  // unsigned Q12.8 squared radius
	localparam int FLD_W     = 16;  // unsigned Q4.12 field value
	localparam int FRAC_W    = 8;   // fraction bits of the grid coordinates
	localparam int AXIS_W    = 16;  // magnitude of one axis difference
	localparam int SQ_W      = 2 * AXIS_W;
	localparam int D2_W      = SQ_W + 1;     // sum of three squares
	localparam int R2_W      = RAD_W + FRAC_W;
	localparam int Q_W       = 17;  // Q1.16 falloff, 0 .. 1.0 inclusive
	localparam int GSQ_W     = 2 * Q_W;
	localparam int TERM_SHIFT = 22;
	localparam int TERM_PROD_W = GSQ_W + 1;  // seven times a value of at most 2^32 (+1)
	localparam int TERM_W    = TERM_PROD_W - TERM_SHIFT;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SUM,
		ST_CMP,
		ST_DIV,
		ST_GSQ,
		ST_TERM,
		ST_ACC,
		ST_EMIT
	} state_t;

	// Magnitude of (voxel << 8) - center. It never exceeds 40704, so 16 bits hold it.
	function automatic logic [AXIS_W-1:0] axis_dist(input logic [VOX_W-1:0] voxel,
	                                                input logic [CEN_W-1:0] center);
		logic [AXIS_W:0] pos;
		logic [AXIS_W:0] cen;
		logic [AXIS_W:0] diff;
		logic [AXIS_W:0] mag;
		pos  = {{(AXIS_W+1-VOX_W-FRAC_W){1'b0}}, voxel, {FRAC_W{1'b0}}};
		cen  = {center[CEN_W-1], center};
		diff = pos - cen;
		mag  = diff[AXIS_W] ? (~diff + 1'b1) : diff;
		return mag[AXIS_W-1:0];
	endfunction

endpackage

### rtl/metaball_field_accumulate.sv
// ----------------------------------------------------------------------------
// Metaball field accumulate
// Sums the metaball falloff 1.75*(1 - d2/r2)^2 of a run of balls at one voxel.
// ----------------------------------------------------------------------------
// The block takes one ball-voxel pair at a time and holds in_ready low until
// that pair is finished. A ball that reaches the voxel passes from one
// accepted transaction to the next through three parallel serial squarers
// (eight two-bit steps and a handoff), the sum and compare, a
// one-bit-per-cycle divider, a serial squaring of the falloff, the scaling and
// the add, and the idle state in which the next transaction is taken; the
// divider is the longest of these steps. A ball that misses the voxel skips
// the divide, the squaring and the scaling. A last ball passes through an emit
// state that loads the output register and waits while the previous result is unread.
// A result waits in an output register, so new pairs flow while it is unread;
// only the next result stalls behind it.
module metaball_field_accumulate
	import mfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [VOX_W-1:0] voxel_x,
	input  logic [VOX_W-1:0] voxel_y,
	input  logic [VOX_W-1:0] voxel_z,
	input  logic [CEN_W-1:0] center_x,
	input  logic [CEN_W-1:0] center_y,
	input  logic [CEN_W-1:0] center_z,
	input  logic [RAD_W-1:0] radius_sq,
	input  logic             first_ball,
	input  logic             last_ball,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [FLD_W-1:0] field_value,
	output logic [VOX_W-1:0] out_x,
	output logic [VOX_W-1:0] out_y,
	output logic [VOX_W-1:0] out_z
);

	state_t state_q, state_nxt;

	logic [VOX_W-1:0] vx_q, vy_q, vz_q;
	logic [RAD_W-1:0] rad_q;
	logic             first_q;
	logic             last_q;
	logic [D2_W-1:0]  d2_q;
	logic [TERM_W-1:0] term_q;
	logic [FLD_W-1:0] sum_q;

	logic             out_valid_q;
	logic [FLD_W-1:0] field_value_q;
	logic [VOX_W-1:0] out_x_q, out_y_q, out_z_q;

	logic             accept;
	logic             sq_start;
	logic             div_start;
	logic             gsq_start;
	logic             out_load;
	logic             out_free;

	logic [2:0]       sq_done;
	logic [SQ_W-1:0]  sq_prod [3];
	logic             div_done;
	logic [Q_W-1:0]   g;
	logic             gsq_done;
	logic [GSQ_W-1:0] g_sq;

	logic [R2_W-1:0]  r2;
	logic             hit;
	logic [R2_W-1:0]  r2_minus_d2;
	logic [TERM_PROD_W-1:0] term_prod;
	logic [FLD_W-1:0] base;
	logic [FLD_W:0]   sum_new;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign r2          = {rad_q, {FRAC_W{1'b0}}};
	assign hit         = d2_q < D2_W'(r2);
	assign r2_minus_d2 = r2 - d2_q[R2_W-1:0];
	assign term_prod   = (TERM_PROD_W'(g_sq) << 3) - TERM_PROD_W'(g_sq);
	assign base        = first_q ? '0 : sum_q;
	assign sum_new     = {1'b0, base} + (FLD_W+1)'(term_q);

	mfa_sqr #(.W(AXIS_W)) u_sqr_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (axis_dist(voxel_x, center_x)),
		.done    (sq_done[0]),
		.product (sq_prod[0])
	);

	mfa_sqr #(.W(AXIS_W)) u_sqr_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (axis_dist(voxel_y, center_y)),
		.done    (sq_done[1]),
		.product (sq_prod[1])
	);

	mfa_sqr #(.W(AXIS_W)) u_sqr_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (axis_dist(voxel_z, center_z)),
		.done    (sq_done[2]),
		.product (sq_prod[2])
	);

	mfa_div #(.DW(R2_W), .QW(Q_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (r2_minus_d2),
		.den      (r2),
		.done     (div_done),
		.quotient (g)
	);

	mfa_sqr #(.W(Q_W)) u_sqr_g (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gsq_start),
		.operand (g),
		.done    (gsq_done),
		.product (g_sq)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_SQ;
			ST_SQ:   if (&sq_done) state_nxt = ST_SUM;
			ST_SUM:  state_nxt = ST_CMP;
			ST_CMP:  state_nxt = hit ? ST_DIV : ST_ACC;
			ST_DIV:  if (div_done) state_nxt = ST_GSQ;
			ST_GSQ:  if (gsq_done) state_nxt = ST_TERM;
			ST_TERM: state_nxt = ST_ACC;
			ST_ACC:  state_nxt = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_IDLE;
		sq_start  = in_valid && (state_q == ST_IDLE);
		div_start = (state_q == ST_CMP) && hit;
		gsq_start = (state_q == ST_DIV) && div_done;
		out_load  = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_ACC) begin
				sum_q <= sum_new[FLD_W] ? '1 : sum_new[FLD_W-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q    <= voxel_x;
			vy_q    <= voxel_y;
			vz_q    <= voxel_z;
			rad_q   <= radius_sq;
			first_q <= first_ball;
			last_q  <= last_ball;
		end
		if (state_q == ST_SUM) begin
			d2_q <= D2_W'(sq_prod[0]) + D2_W'(sq_prod[1]) + D2_W'(sq_prod[2]);
		end
		// A ball that misses the voxel adds nothing.
		if (state_q == ST_CMP) begin
			term_q <= '0;
		end else if (state_q == ST_TERM) begin
			term_q <= term_prod[TERM_PROD_W-1:TERM_SHIFT];
		end
		if (out_load) begin
			field_value_q <= sum_q;
			out_x_q       <= vx_q;
			out_y_q       <= vy_q;
			out_z_q       <= vz_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_value = field_value_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z       = out_z_q;

endmodule

### rtl/mfa_sqr.sv
// ----------------------------------------------------------------------------
// Serial squarer
// Squares an unsigned operand two multiplier bits per cycle, most significant
// digit first, with a shift-and-add accumulator.
// ----------------------------------------------------------------------------
module mfa_sqr
	import mfa_pkg::*;
#(
	parameter int W = AXIS_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   operand,
	output logic           done,
	output logic [2*W-1:0] product
);

	localparam int NDIG = (W + 1) / 2;
	localparam int CW   = $clog2(NDIG + 1);

	logic [W-1:0]      a_q;
	logic [2*NDIG-1:0] mult_q;
	logic [2*W-1:0]    acc_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [1:0]   digit;
	logic [W+1:0] a3;
	logic [W+1:0] pp;

	assign digit = mult_q[2*NDIG-1 -: 2];
	assign a3    = {2'b00, a_q} + {1'b0, a_q, 1'b0};

	always_comb begin
		unique case (digit)
			2'd0:    pp = '0;
			2'd1:    pp = {2'b00, a_q};
			2'd2:    pp = {1'b0, a_q, 1'b0};
			default: pp = a3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NDIG);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The running value is always the operand times a prefix of itself, so it
	// never outgrows the final square.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= operand;
			mult_q <= (2*NDIG)'(operand);
			acc_q  <= '0;
		end else if (busy_q) begin
			mult_q <= mult_q << 2;
			acc_q  <= (acc_q << 2) + (2*W)'(pp);
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### rtl/mfa_div.sv
// ----------------------------------------------------------------------------
// Serial fraction divider
// Restoring divider for a numerator no larger than the divisor. It returns
// floor((num << (QW-1)) / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfa_div
	import mfa_pkg::*;
#(
	parameter int DW = R2_W,
	parameter int QW = Q_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int CW = $clog2(QW + 1);

	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic          qbit;
	logic [DW:0]   rem_sub;

	assign qbit    = rem_q >= {1'b0, den_q};
	assign rem_sub = qbit ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// After a subtraction the remainder is below the divisor, so doubling it
	// still fits one bit above the divisor width.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sub[DW-1:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metaball field accumulate testbench
// Drives runs of ball-voxel pairs with random bursts and output stalls, and
// checks every voxel result against a cycle-free model of the field sum.
// ----------------------------------------------------------------------------
module testbench;
	import mfa_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int TOTAL_PAIRS  = 1400;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [FLD_W-1:0] FIELD_MAX     = '1;
	localparam logic [RAD_W-1:0] RADIUS_SQ_MAX = '1;
	localparam logic [CEN_W-1:0] CENTER_MIN    = 16'h8000;
	localparam logic [CEN_W-1:0] CENTER_MAX    = 16'h7FFF;

	typedef struct {
		logic [VOX_W-1:0] vx, vy, vz;
		logic [CEN_W-1:0] cx, cy, cz;
		logic [RAD_W-1:0] rsq;
		logic             first;
		logic             last;
	} ball_pair_t;

	typedef struct {
		logic [FLD_W-1:0] field;
		logic [VOX_W-1:0] x, y, z;
	} voxel_result_t;

	typedef enum {RCV_OPEN, RCV_RANDOM, RCV_BURSTY} rcv_mode_t;

	class field_scoreboard;
		logic [FLD_W-1:0] field_sum;
		voxel_result_t    pending_results[$];
		int               errors, pairs, hits, results, saturated;

		function new();
			field_sum = '0;
			errors = 0;
			pairs = 0;
			hits = 0;
			results = 0;
			saturated = 0;
		endfunction

		function longint unsigned axis_sq(logic [VOX_W-1:0] voxel, logic [CEN_W-1:0] center);
			longint diff;
			diff = (longint'(voxel) << FRAC_W) - longint'($signed(center));
			return diff * diff;
		endfunction

		// Advances the running field sum by one pair and queues the voxel
		// result when the pair closes the run.
		function void note_ball(ball_pair_t p);
			longint unsigned d2, r2, g, term, total;
			voxel_result_t   r;
			pairs++;
			d2 = axis_sq(p.vx, p.cx) + axis_sq(p.vy, p.cy) + axis_sq(p.vz, p.cz);
			r2 = p.rsq;
			r2 = r2 << FRAC_W;
			if (p.first)
				field_sum = '0;
			if (d2 < r2) begin
				hits++;
				g = ((r2 - d2) << 16) / r2;
				term = (7 * g * g) >> TERM_SHIFT;
				total = field_sum + term;
				field_sum = (total > FIELD_MAX) ? FIELD_MAX : total[FLD_W-1:0];
			end
			if (p.last) begin
				r.field = field_sum;
				r.x = p.vx;
				r.y = p.vy;
				r.z = p.vz;
				pending_results.push_back(r);
				if (field_sum == FIELD_MAX)
					saturated++;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR at %0t: %s", $time, msg);
		endtask

		task check_voxel_result(voxel_result_t got);
			voxel_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result field %0d at (%0d,%0d,%0d)",
					got.field, got.x, got.y, got.z));
				return;
			end
			want = pending_results.pop_front();
			results++;
			if (got.field !== want.field)
				report($sformatf("field_value %0d, wanted %0d", got.field, want.field));
			if (got.x !== want.x)
				report($sformatf("out_x %0d, wanted %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("out_y %0d, wanted %0d", got.y, want.y));
			if (got.z !== want.z)
				report($sformatf("out_z %0d, wanted %0d", got.z, want.z));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [VOX_W-1:0] voxel_x, voxel_y, voxel_z;
	logic [CEN_W-1:0] center_x, center_y, center_z;
	logic [RAD_W-1:0] radius_sq;
	logic             first_ball;
	logic             last_ball;
	logic             out_valid;
	logic             out_ready;
	logic [FLD_W-1:0] field_value;
	logic [VOX_W-1:0] out_x, out_y, out_z;

	field_scoreboard field_sb;
	rcv_mode_t       rcv_mode;
	int              stall_left = 0;
	int              idle_cycles = 0;
	int              burst_left = 0;
	int              sent_pairs = 0;

	metaball_field_accumulate uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.voxel_x     (voxel_x),
		.voxel_y     (voxel_y),
		.voxel_z     (voxel_z),
		.center_x    (center_x),
		.center_y    (center_y),
		.center_z    (center_z),
		.radius_sq   (radius_sq),
		.first_ball  (first_ball),
		.last_ball   (last_ball),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_value (field_value),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z)
	);

	always #HALF_PERIOD clk = ~clk;

	// The receiver switches between always ready, ready six times in ten and long stalls.
	always @(negedge clk) begin
		case (rcv_mode)
			RCV_OPEN: out_ready <= 1'b1;
			RCV_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
			default: begin
				if (stall_left != 0) begin
					stall_left <= stall_left - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : 0;
				end
			end
		endcase
	end

	always @(posedge clk) begin : monitor
		ball_pair_t    p;
		voxel_result_t got;
		if (arst_n) begin
			// A result leaving at this edge always belongs to an earlier pair.
			if (out_valid && out_ready) begin
				got.field = field_value;
				got.x = out_x;
				got.y = out_y;
				got.z = out_z;
				field_sb.check_voxel_result(got);
			end
			if (in_valid && in_ready) begin
				p.vx = voxel_x;
				p.vy = voxel_y;
				p.vz = voxel_z;
				p.cx = center_x;
				p.cy = center_y;
				p.cz = center_z;
				p.rsq = radius_sq;
				p.first = first_ball;
				p.last = last_ball;
				field_sb.note_ball(p);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic [VOX_W-1:0] vx, vy, vz,
	                         input logic [CEN_W-1:0] cx, cy, cz,
	                         input logic [RAD_W-1:0] rsq,
	                         input logic first, last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		voxel_x    <= vx;
		voxel_y    <= vy;
		voxel_z    <= vz;
		center_x   <= cx;
		center_y   <= cy;
		center_z   <= cz;
		radius_sq  <= rsq;
		first_ball <= first;
		last_ball  <= last;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent_pairs++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (field_sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_directed();
		// Ball centered on the voxel with the largest radius, and at the far corner.
		send_item(5'd0, 5'd0, 5'd0, 16'd0, 16'd0, 16'd0, RADIUS_SQ_MAX, 1'b1, 1'b1);
		send_item(5'd31, 5'd31, 5'd31, 16'd7936, 16'd7936, 16'd7936, 20'd1, 1'b1, 1'b1);
		// A zero radius never contributes.
		send_item(5'd5, 5'd5, 5'd5, 16'd1280, 16'd1280, 16'd1280, 20'd0, 1'b1, 1'b1);
		// Centers at both ends of their range miss the voxel.
		send_item(5'd31, 5'd31, 5'd31, CENTER_MIN, CENTER_MIN, CENTER_MIN, RADIUS_SQ_MAX,
			1'b1, 1'b1);
		send_item(5'd0, 5'd0, 5'd0, CENTER_MAX, CENTER_MAX, CENTER_MAX, RADIUS_SQ_MAX,
			1'b0, 1'b1);
		// Ten full-strength balls drive the sum into saturation.
		for (int i = 0; i < 10; i++)
			send_item(5'd10, 5'd10, 5'd10, 16'd2560, 16'd2560, 16'd2560, RADIUS_SQ_MAX,
				i == 0, i == 9);
		// Emitting does not clear, so a run with no first ball starts saturated.
		send_item(5'd10, 5'd10, 5'd10, 16'd2560, 16'd2560, 16'd2560, RADIUS_SQ_MAX,
			1'b0, 1'b1);
		// A two-ball run: the first ball resets the sum and the second keeps adding.
		send_item(5'd3, 5'd7, 5'd20, 16'd800, 16'd1700, 16'd5100, 20'd4000, 1'b1, 1'b0);
		send_item(5'd3, 5'd7, 5'd20, 16'd700, 16'd1800, 16'd5200, 20'd4000, 1'b0, 1'b1);
		// Distance a sixteenth of the radius, then exactly on it.
		send_item(5'd0, 5'd0, 5'd0, 16'd1, 16'd0, 16'd0, 20'd1, 1'b1, 1'b1);
		send_item(5'd0, 5'd0, 5'd0, 16'd16, 16'd0, 16'd0, 20'd1, 1'b1, 1'b1);
	endtask

	task automatic send_voxel_run();
		logic [VOX_W-1:0] vx, vy, vz;
		logic [CEN_W-1:0] cen [3];
		logic [RAD_W-1:0] rsq;
		int               balls, span;
		int               off [3];
		int unsigned      rs;
		vx = VOX_W'($urandom_range(0, 31));
		vy = VOX_W'($urandom_range(0, 31));
		vz = VOX_W'($urandom_range(0, 31));
		balls = $urandom_range(1, 8);
		for (int i = 0; i < balls; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				cen[0] = CEN_W'($urandom);
				cen[1] = CEN_W'($urandom);
				cen[2] = CEN_W'($urandom);
				rsq = RAD_W'($urandom);
			end else begin
				// Keep the ball near the voxel so that most pairs take the divide path.
				span = $urandom_range(0, 1 << $urandom_range(4, 12));
				for (int a = 0; a < 3; a++)
					off[a] = $urandom_range(0, 2 * span) - span;
				cen[0] = CEN_W'((int'(vx) << FRAC_W) + off[0]);
				cen[1] = CEN_W'((int'(vy) << FRAC_W) + off[1]);
				cen[2] = CEN_W'((int'(vz) << FRAC_W) + off[2]);
				rs = ((span * span * $urandom_range(1, 4)) >> FRAC_W) + $urandom_range(0, 255);
				rsq = (rs > RADIUS_SQ_MAX) ? RADIUS_SQ_MAX : rs[RAD_W-1:0];
			end
			send_item(vx, vy, vz, cen[0], cen[1], cen[2], rsq, i == 0, i == balls - 1);
		end
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n)
			send_item(VOX_W'($urandom), VOX_W'($urandom), VOX_W'($urandom),
				CEN_W'($urandom), CEN_W'($urandom), CEN_W'($urandom),
				RAD_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		field_sb   = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		voxel_x    = '0;
		voxel_y    = '0;
		voxel_z    = '0;
		center_x   = '0;
		center_y   = '0;
		center_z   = '0;
		radius_sq  = '0;
		first_ball = 1'b0;
		last_ball  = 1'b0;
		out_ready  = 1'b0;
		rcv_mode   = RCV_OPEN;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		send_directed();
		wait_for_results();

		while (sent_pairs < TOTAL_PAIRS) begin
			rcv_mode = rcv_mode_t'($urandom_range(0, 2));
			if ($urandom_range(0, 49) == 0)
				wait_for_results();
			if ($urandom_range(0, 6) == 0)
				send_noise();
			else
				send_voxel_run();
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d ball-voxel pairs: %0d inside their ball, %0d outside.",
			field_sb.pairs, field_sb.hits, field_sb.pairs - field_sb.hits);
		$display("Compared %0d voxel results, %0d at the saturation limit, %0d errors.",
			field_sb.results, field_sb.saturated, field_sb.errors);
		if (field_sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
